// ===== hdl/tun_pkg.sv =====
package tun_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned NormW   = 16;
  localparam int unsigned NormFrac = 14;
  localparam int unsigned ScaleTop = 30;
  localparam int unsigned EdgeW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * EdgeW;
  localparam int unsigned CrossW  = ProdW + 1;
  localparam int unsigned MagW    = CrossW;
  localparam int unsigned AW      = ScaleTop + 1;
  localparam int unsigned SumW    = 2 * AW + 2;
  localparam int unsigned LenW    = SumW / 2;
  localparam int unsigned NumW    = AW + NormFrac;
  localparam int unsigned QW      = NormFrac + 2;

  typedef struct packed {
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic signed [CoordW-1:0] base_z;
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_z;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } tun_out_t;

  // per-item flags riding along the pipe
  typedef struct packed {
    logic       water;
    logic       zero;
    logic [2:0] neg;
  } tun_flags_t;

endpackage

// ===== hdl/tun_sqrt_stage.sv =====
// One restoring step of the bit-pair square root.
module tun_sqrt_stage import tun_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic [SumW-1:0] rem_i,
  input  logic [SumW-1:0] root_i,
  output logic [SumW-1:0] rem_o,
  output logic [SumW-1:0] root_o
);
  // running root is full width until the last step
  logic [SumW-1:0] trial;
  logic [SumW-1:0] bitv;
  always_comb begin
    bitv  = SumW'(1) << (2 * (LenW - 1 - Step));
    trial = root_i + bitv;
    if (rem_i >= trial) begin
      rem_o  = rem_i - trial;
      root_o = (root_i >> 1) + bitv;
    end else begin
      rem_o  = rem_i;
      root_o = root_i >> 1;
    end
  end
endmodule

// ===== hdl/tun_div_stage.sv =====
// One restoring step of the unsigned divide, quotient bit Bit.
module tun_div_stage import tun_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic [NumW:0]   rem_i,
  input  logic [LenW-1:0] den_i,
  input  logic [QW-1:0]   q_i,
  output logic [NumW:0]   rem_o,
  output logic [QW-1:0]   q_o
);
  logic [NumW+QW:0] sh;
  always_comb begin
    sh    = {{QW{1'b0}}, den_i, {(NumW+1-LenW){1'b0}}} << Bit;
    sh    = sh >> (NumW + 1 - LenW);
    q_o   = q_i;
    rem_o = rem_i;
    if ({{QW{1'b0}}, rem_i} >= sh) begin
      rem_o  = rem_i - (NumW+1)'(sh);
      q_o[Bit] = 1'b1;
    end
  end
endmodule

// ===== hdl/triangle_unit_normal.sv =====
// Triangle unit face normal, fully pipelined.
// Input channel in_valid_i / in_stall_o carries one word of nine signed Q4.12
// coordinates: a base vertex and two neighbors. Output channel out_valid_o /
// out_stall_i carries one word per input: a signed Q1.14 unit normal and a
// degenerate flag (zero-length cross product, normal zero).
// A base height of exactly zero returns the up vector (0, 1.0, 0).
// Flow: edges, cross product (one 17x17 multiply per register), magnitude
// and block scaling, three squares, sum, a square root at one result bit
// per stage, then three dividers at one quotient bit per stage, sign fix.
// Throughput is one word per cycle while in_stall_o is low; the pipe has
// 7 front stages, 32 root stages, 17 divide stages and the output register.
// When out_stall_i is high and the last stage holds a word, that word moves
// into a one-word skid register; while the skid register is full every stage
// holds and in_stall_o is high, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// The block holds no other state and has no configuration.
module triangle_unit_normal import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tun_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tun_out_t out_data_o
);
  localparam int unsigned NDiv = QW;
  localparam int unsigned Depth = 8 + LenW + NDiv + 1;

  logic     adv;
  logic     pipe_vld;
  logic     skid_vld_q;
  tun_out_t skid_q;
  assign adv = !skid_vld_q;
  assign in_stall_o = !adv;

  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stage 1: edges
  logic signed [EdgeW-1:0] e1_q [3], e2_q [3];
  logic water1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q[0] <= EdgeW'(in_data_i.first_x)  - EdgeW'(in_data_i.base_x);
      e1_q[1] <= EdgeW'(in_data_i.first_y)  - EdgeW'(in_data_i.base_y);
      e1_q[2] <= EdgeW'(in_data_i.first_z)  - EdgeW'(in_data_i.base_z);
      e2_q[0] <= EdgeW'(in_data_i.second_x) - EdgeW'(in_data_i.base_x);
      e2_q[1] <= EdgeW'(in_data_i.second_y) - EdgeW'(in_data_i.base_y);
      e2_q[2] <= EdgeW'(in_data_i.second_z) - EdgeW'(in_data_i.base_z);
      water1_q <= (in_data_i.base_y == '0);
    end
  end

  // stage 2: six products
  logic signed [ProdW-1:0] pr_q [6];
  logic water2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= e1_q[1] * e2_q[2];
      pr_q[1] <= e1_q[2] * e2_q[1];
      pr_q[2] <= e1_q[2] * e2_q[0];
      pr_q[3] <= e1_q[0] * e2_q[2];
      pr_q[4] <= e1_q[0] * e2_q[1];
      pr_q[5] <= e1_q[1] * e2_q[0];
      water2_q <= water1_q;
    end
  end

  // stage 3: cross product magnitudes and signs
  logic [MagW-1:0] mag_q [3];
  tun_flags_t f3_q;
  logic signed [CrossW-1:0] cr [3];
  always_comb begin
    cr[0] = CrossW'(pr_q[0]) - CrossW'(pr_q[1]);
    cr[1] = CrossW'(pr_q[2]) - CrossW'(pr_q[3]);
    cr[2] = CrossW'(pr_q[4]) - CrossW'(pr_q[5]);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]    <= cr[i][CrossW-1] ? MagW'(-cr[i]) : MagW'(cr[i]);
        f3_q.neg[i] <= cr[i][CrossW-1];
      end
      f3_q.water <= water2_q;
      f3_q.zero  <= 1'b0;
    end
  end

  // stage 4: common shift amount from the OR of magnitudes
  logic [MagW-1:0] orv;
  logic [$clog2(MagW)-1:0] msb;
  always_comb begin
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    msb = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv[i]) msb = ($clog2(MagW))'(i);
    end
  end
  logic [MagW-1:0] mag4_q [3];
  logic [$clog2(MagW)-1:0] msb4_q;
  tun_flags_t f4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag4_q <= mag_q;
      msb4_q <= msb;
      f4_q   <= '{water: f3_q.water, zero: (orv == '0), neg: f3_q.neg};
    end
  end

  // stage 5: block scaling so the largest lies in [2^30, 2^31)
  logic [AW-1:0] a5_q [3];
  tun_flags_t f5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (msb4_q > ($clog2(MagW))'(ScaleTop)) begin
          a5_q[i] <= AW'(mag4_q[i] >> (msb4_q - ($clog2(MagW))'(ScaleTop)));
        end else begin
          a5_q[i] <= AW'(mag4_q[i] << (($clog2(MagW))'(ScaleTop) - msb4_q));
        end
      end
      f5_q <= f4_q;
    end
  end

  // stage 6: squares
  logic [2*AW-1:0] sq_q [3];
  logic [AW-1:0] a6_q [3];
  tun_flags_t f6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= a5_q[i] * a5_q[i];
      a6_q <= a5_q;
      f6_q <= f5_q;
    end
  end

  // stage 7: sum, first row of the root pipe
  logic [SumW-1:0] sr_rem_q [LenW+1];
  logic [SumW-1:0] sr_root_q [LenW+1];
  logic [AW-1:0]   sr_a_q [LenW+1][3];
  tun_flags_t      sr_f_q [LenW+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_rem_q[0]  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      sr_root_q[0] <= '0;
      sr_a_q[0]    <= a6_q;
      sr_f_q[0]    <= f6_q;
    end
  end

  // square root: one result bit per stage
  for (genvar s = 0; s < LenW; s++) begin : g_sqrt
    logic [SumW-1:0] rem_n;
    logic [SumW-1:0] root_n;
    tun_sqrt_stage #(.Step(s)) u_step (
      .rem_i (sr_rem_q[s]), .root_i(sr_root_q[s]),
      .rem_o (rem_n),       .root_o(root_n)
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_rem_q[s+1]  <= rem_n;
        sr_root_q[s+1] <= root_n;
        sr_a_q[s+1]    <= sr_a_q[s];
        sr_f_q[s+1]    <= sr_f_q[s];
      end
    end
  end

  // divide setup: numerator = a * 2^frac + len/2, guard zero length
  logic [LenW-1:0] len;
  assign len = (sr_root_q[LenW] == '0) ? LenW'(1) : LenW'(sr_root_q[LenW]);

  logic [NumW:0]   dv_rem_q [NDiv+1][3];
  logic [QW-1:0]   dv_q_q   [NDiv+1][3];
  logic [LenW-1:0] dv_den_q [NDiv+1];
  tun_flags_t      dv_f_q   [NDiv+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= (NumW+1)'({sr_a_q[LenW][i], {NormFrac{1'b0}}}) +
                          (NumW+1)'(len >> 1);
        dv_q_q[0][i]   <= '0;
      end
      dv_den_q[0] <= len;
      dv_f_q[0]   <= sr_f_q[LenW];
    end
  end
  for (genvar b = 0; b < NDiv; b++) begin : g_div
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [NumW:0] rem_n;
      logic [QW-1:0] q_n;
      tun_div_stage #(.Bit(NDiv-1-b)) u_step (
        .rem_i(dv_rem_q[b][c]), .den_i(dv_den_q[b]), .q_i(dv_q_q[b][c]),
        .rem_o(rem_n),          .q_o  (q_n)
      );
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_rem_q[b+1][c] <= rem_n;
          dv_q_q[b+1][c]   <= q_n;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_den_q[b+1] <= dv_den_q[b];
        dv_f_q[b+1]   <= dv_f_q[b];
      end
    end
  end

  // output register: sign, special cases
  tun_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      priority if (dv_f_q[NDiv].water) begin
        out_q <= '{normal_x: '0, normal_y: NormW'(1) << NormFrac,
                   normal_z: '0, degenerate: 1'b0};
      end else if (dv_f_q[NDiv].zero) begin
        out_q <= '{normal_x: '0, normal_y: '0, normal_z: '0, degenerate: 1'b1};
      end else begin
        out_q.normal_x <= dv_f_q[NDiv].neg[0] ? -NormW'(dv_q_q[NDiv][0])
                                              :  NormW'(dv_q_q[NDiv][0]);
        out_q.normal_y <= dv_f_q[NDiv].neg[1] ? -NormW'(dv_q_q[NDiv][1])
                                              :  NormW'(dv_q_q[NDiv][1]);
        out_q.normal_z <= dv_f_q[NDiv].neg[2] ? -NormW'(dv_q_q[NDiv][2])
                                              :  NormW'(dv_q_q[NDiv][2]);
        out_q.degenerate <= 1'b0;
      end
    end
  end

  // skid register: takes the last word when the receiver stalls
  assign pipe_vld = vld_q[Depth-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (!out_stall_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (pipe_vld && out_stall_i) begin
      skid_vld_q <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && pipe_vld && out_stall_i) begin
      skid_q <= out_q;
    end
  end

  assign out_valid_o = skid_vld_q || pipe_vld;
  assign out_data_o  = skid_vld_q ? skid_q : out_q;
endmodule

// ===== dv/tb_triangle_unit_normal.sv =====
module tb_triangle_unit_normal;
  import tun_pkg::*;

  // Testbench for the triangle face normal unit.
  // A scoreboard class predicts each normal as the input word is accepted and
  // checks output words in order. The sender drives words in bursts with gaps,
  // and the receiver stalls on a pattern of its own. One long stall fills the
  // pipe so that in_stall_o must rise.

  localparam int NumRandom  = 2000;
  localparam int DrainWait  = 120;
  localparam int CycleLimit = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tun_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tun_out_t out_data_o;

  int  cycle_count;
  int  error_count;
  bit  hold_request;  // asks the receiver for one long stall

  triangle_unit_normal uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Predicts unit normals and checks that they arrive in order.
  class normal_scoreboard;
    tun_out_t pending_q[$];

    // Integer square root, rounded down.
    static function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function automatic tun_out_t predict_normal(tun_in_t w);
      tun_out_t        res;
      longint          e1[3];
      longint          e2[3];
      longint          cr[3];
      longint unsigned mag[3];
      longint unsigned sc[3];
      longint unsigned peak;
      longint unsigned len;
      longint unsigned quo;
      int              top;
      res = '0;
      if (w.base_y == 0) begin
        // water level: straight up
        res.normal_y = 16'sd1 <<< NormFrac;
        return res;
      end
      e1[0] = longint'(w.first_x) - longint'(w.base_x);
      e1[1] = longint'(w.first_y) - longint'(w.base_y);
      e1[2] = longint'(w.first_z) - longint'(w.base_z);
      e2[0] = longint'(w.second_x) - longint'(w.base_x);
      e2[1] = longint'(w.second_y) - longint'(w.base_y);
      e2[2] = longint'(w.second_z) - longint'(w.base_z);
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      peak = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (cr[i] < 0) ? unsigned'(-cr[i]) : unsigned'(cr[i]);
        if (mag[i] > peak) peak = mag[i];
      end
      if (peak == 0) begin
        res.degenerate = 1'b1;
        return res;
      end
      top = 0;
      while (top < 63 && (peak >> (top + 1)) != 0) top++;
      // block scale so the largest magnitude sits in [2^30, 2^31)
      for (int i = 0; i < 3; i++)
        sc[i] = (top > ScaleTop) ? mag[i] >> (top - ScaleTop) : mag[i] << (ScaleTop - top);
      len = root_floor(sc[0] * sc[0] + sc[1] * sc[1] + sc[2] * sc[2]);
      for (int i = 0; i < 3; i++) begin
        quo = ((sc[i] << NormFrac) + (len >> 1)) / len;
        if (cr[i] < 0) quo = -quo;
        case (i)
          0: res.normal_x = quo[NormW-1:0];
          1: res.normal_y = quo[NormW-1:0];
          default: res.normal_z = quo[NormW-1:0];
        endcase
      end
      return res;
    endfunction

    function void note_input(tun_in_t w);
      pending_q.push_back(predict_normal(w));
    endfunction

    function void check_output(tun_out_t got);
      tun_out_t exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        error_count++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.normal_x !== exp_w.normal_x) begin
        $display("%0t: normal_x exp %0d got %0d", $time, exp_w.normal_x, got.normal_x);
        error_count++;
      end
      if (got.normal_y !== exp_w.normal_y) begin
        $display("%0t: normal_y exp %0d got %0d", $time, exp_w.normal_y, got.normal_y);
        error_count++;
      end
      if (got.normal_z !== exp_w.normal_z) begin
        $display("%0t: normal_z exp %0d got %0d", $time, exp_w.normal_z, got.normal_z);
        error_count++;
      end
      if (got.degenerate !== exp_w.degenerate) begin
        $display("%0t: degenerate exp %0b got %0b", $time, exp_w.degenerate,
                 got.degenerate);
        error_count++;
      end
    endfunction
  endclass

  normal_scoreboard normals = new();
  tun_in_t          triangle_q[$];

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Both sides sampled at the edge; accepted words go to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (in_valid_i && !in_stall_o) normals.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) normals.check_output(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("** triangle_unit_normal: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tun_in_t rand_triangle();
    tun_in_t w;
    w.base_x   = rand_coord();
    w.base_y   = ($urandom_range(0, 19) == 0) ? 16'sd0 : rand_coord();
    w.base_z   = rand_coord();
    w.first_x  = rand_coord();
    w.first_y  = rand_coord();
    w.first_z  = rand_coord();
    w.second_x = rand_coord();
    w.second_y = rand_coord();
    w.second_z = rand_coord();
    case ($urandom_range(0, 15))
      0: begin
        // repeated vertex: zero-length cross product
        w.second_x = w.first_x;
        w.second_y = w.first_y;
        w.second_z = w.first_z;
      end
      1: begin
        w.first_x = w.base_x;
        w.first_y = w.base_y;
        w.first_z = w.base_z;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Offer one word and hold it until accepted.
  task automatic send_word(tun_in_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic build_directed();
    tun_in_t w;
    w = '0;
    w.base_y = 16'sd1;
    w.first_x = 16'sd1;
    w.second_z = 16'sd1;
    triangle_q.push_back(w);             // small unit-ish triangle
    w = '0;
    triangle_q.push_back(w);             // water level, all zero
    w = '1;
    w.base_y = '0;
    triangle_q.push_back(w);             // water level, other fields busy
    w = '0;
    w.base_y = 16'sd5;
    triangle_q.push_back(w);             // both neighbors equal: degenerate
    w = '0;
    w.base_y = 16'sh7fff;
    w.first_x = 16'sh7fff;
    w.first_y = 16'sh8000;
    w.second_z = 16'sh8000;
    w.second_y = 16'sh8000;
    triangle_q.push_back(w);             // largest edges
    w = '0;
    w.base_x = 16'sh8000;
    w.base_y = 16'sh8000;
    w.base_z = 16'sh8000;
    w.first_x = 16'sh7fff;
    w.first_y = 16'sh7fff;
    w.first_z = 16'sh8000;
    w.second_x = 16'sh8000;
    w.second_y = 16'sh7fff;
    w.second_z = 16'sh7fff;
    triangle_q.push_back(w);             // most negative base, max spans
    w = '0;
    w.base_y = -16'sd1;
    w.first_x = 16'sd2;
    w.first_y = 16'sd4;
    w.first_z = 16'sd6;
    w.second_x = 16'sd1;
    w.second_y = 16'sd2;
    w.second_z = 16'sd3;
    triangle_q.push_back(w);             // edges not collinear: not degenerate
    w = '0;
    w.base_y = 16'sd1;
    w.first_z = 16'sd1;
    w.second_x = 16'sd1;
    triangle_q.push_back(w);             // reversed winding
    w = '1;
    triangle_q.push_back(w);             // all ones
    for (int i = 0; i < 8; i++) triangle_q.push_back(rand_triangle());
  endtask

  // Receiver: random stall pattern, one long hold-off on request.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 150; hold++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (cycle_count % 400 < 100) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    int burst;
    int drain;
    cycle_count  = 0;
    error_count  = 0;
    hold_request = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    rst_ni       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed();
    for (int i = 0; i < NumRandom; i++) triangle_q.push_back(rand_triangle());

    while (triangle_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && triangle_q.size() > 0) begin
        if (triangle_q.size() == NumRandom / 2) hold_request = 1'b1;
        send_word(triangle_q.pop_front());
        burst--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;

    while (normals.pending_q.size() > 0) @(posedge clk_i);
    for (drain = 0; drain < DrainWait; drain++) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** triangle_unit_normal: PASSED **");
    end else begin
      $display("** triangle_unit_normal: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tun_pkg.sv
hdl/tun_sqrt_stage.sv
hdl/tun_div_stage.sv
hdl/triangle_unit_normal.sv
dv/tb_triangle_unit_normal.sv
